@@ rtl/core/sled_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sled_pkg: shared types and constants for the string literal escape decoder
// Phase codes, fault codes, character constants, byte class helpers and the
// result record passed from the step logic to the top level.
// ----------------------------------------------------------------------------
package sled_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_BODY  = 3'd1,
        PH_ESC   = 3'd2,
        PH_HEX2  = 3'd3,
        PH_LNSKP = 3'd4,
        PH_JOIN  = 3'd5
    } t_phase;

    localparam logic [1:0] FLT_NONE     = 2'd0;
    localparam logic [1:0] FLT_BAD_ESC  = 2'd1;
    localparam logic [1:0] FLT_BAD_STR  = 2'd2;
    localparam logic [1:0] FLT_NO_QUOTE = 2'd3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_N   = 8'h6e;
    localparam logic [7:0] CH_LO_T   = 8'h74;

    typedef struct packed {
        logic       vld;
        logic [7:0] char_out;
        logic       char_valid;
        logic       finished;
        logic       byte_taken;
        logic [1:0] fault;
    } t_result;

    function automatic logic is_hex(input logic [7:0] b);
        return ((b >= CH_ZERO) && (b <= CH_NINE)) || ((b >= CH_LO_A) && (b <= CH_LO_F));
    endfunction

    // Only valid for bytes that pass is_hex.
    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        v = (b <= CH_NINE) ? (b - CH_ZERO) : (b - CH_LO_A + 8'd10);
        return v[3:0];
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_CR) || (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/string_literal_escape_decoder_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// string_literal_escape_decoder_unit: quoted string literal decoder
// Decodes a quoted literal one source byte at a time and emits content bytes,
// end markers and faults.
// ----------------------------------------------------------------------------
// One source byte is accepted per clock while the input is not stalled. Each
// byte lands in an input register, the decode step runs as combinational logic
// against the phase register, and the outcome goes to the result register,
// from which it is presented. Bytes that produce no result (opening quote,
// backslash, first hex digit, skipped whitespace) leave the result register
// empty. The input stalls only while the result register is full and the output
// is stalled. The mode register is written through the config channel, which is
// always ready; write it only while no literal is in progress.
module string_literal_escape_decoder_unit
    import sled_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_preproc_mode,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_src_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_char_out,
    output logic       o_char_valid,
    output logic       o_finished,
    output logic       o_byte_taken,
    output logic [1:0] o_fault
);

    logic       r_preproc;
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    t_phase     r_phase;
    logic [3:0] r_hex_high;
    logic       r_out_vld;
    t_result    r_res;

    logic       n_in_vld;
    t_phase     n_phase;
    logic [3:0] n_hex_high;
    t_result    n_res;
    logic       adv;

    sled_step u_step (
        .i_phase    (r_phase),
        .i_hex_high (r_hex_high),
        .i_preproc  (r_preproc),
        .i_byte     (r_in_byte),
        .o_phase    (n_phase),
        .o_hex_high (n_hex_high),
        .o_res      (n_res)
    );

    // the step stage moves whenever the result register can take a transfer
    assign adv         = !r_out_vld || !i_out_stall;
    assign o_in_stall  = r_in_vld && !adv;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_in_vld = r_in_vld;
        if (i_in_valid && !o_in_stall) begin
            n_in_vld = 1'b1;
        end else if (adv) begin
            n_in_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preproc  <= 1'b0;
            r_in_vld   <= 1'b0;
            r_phase    <= PH_IDLE;
            r_hex_high <= 4'd0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_preproc <= i_cfg_preproc_mode;
            end
            r_in_vld <= n_in_vld;
            if (adv) begin
                r_out_vld <= r_in_vld && n_res.vld;
                if (r_in_vld) begin
                    r_phase    <= n_phase;
                    r_hex_high <= n_hex_high;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_src_byte;
        end
        if (adv && r_in_vld) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_char_out   = r_res.char_out;
    assign o_char_valid = r_res.char_valid;
    assign o_finished   = r_res.finished;
    assign o_byte_taken = r_res.byte_taken;
    assign o_fault      = r_res.fault;

endmodule

`default_nettype wire

@@ rtl/core/sled_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sled_step: per-byte decode step
// Combinational transition of the literal decoder: from the current phase,
// pending hex digit, mode and source byte it forms the next phase and the
// result record for this byte.
// ----------------------------------------------------------------------------
module sled_step
    import sled_pkg::*;
(
    input  t_phase     i_phase,
    input  logic [3:0] i_hex_high,
    input  logic       i_preproc,
    input  logic [7:0] i_byte,
    output t_phase     o_phase,
    output logic [3:0] o_hex_high,
    output t_result    o_res
);

    logic b_hex;
    logic b_space;
    logic b_simple_esc;
    logic body_go;

    assign b_hex        = is_hex(i_byte);
    assign b_space      = is_space(i_byte);
    assign b_simple_esc = (i_byte == CH_LO_N) || (i_byte == CH_LO_T) ||
                          (i_byte == CH_QUOTE) || (i_byte == CH_BSLASH);
    // a non-space byte after a raw newline is handled like a body byte
    assign body_go      = (i_phase == PH_BODY) || ((i_phase == PH_LNSKP) && !b_space);

    // next state
    always_comb begin
        o_phase    = i_phase;
        o_hex_high = i_hex_high;
        if (body_go) begin
            if (i_byte == CH_QUOTE) begin
                o_phase = i_preproc ? PH_IDLE : PH_JOIN;
            end else if (i_byte == CH_BSLASH) begin
                o_phase = PH_ESC;
            end else if (i_byte == CH_LF) begin
                if (i_preproc) begin
                    o_phase    = PH_IDLE;
                    o_hex_high = 4'd0;
                end else begin
                    o_phase = PH_LNSKP;
                end
            end else if (i_byte == CH_NUL) begin
                o_phase    = PH_IDLE;
                o_hex_high = 4'd0;
            end else begin
                o_phase = PH_BODY;
            end
        end else begin
            case (i_phase)
                PH_LNSKP: begin
                    o_phase = PH_LNSKP;
                end
                PH_ESC: begin
                    if (b_hex) begin
                        o_phase    = PH_HEX2;
                        o_hex_high = hex_val(i_byte);
                    end else if (b_simple_esc) begin
                        o_phase = PH_BODY;
                    end else begin
                        o_phase    = PH_IDLE;
                        o_hex_high = 4'd0;
                    end
                end
                PH_HEX2: begin
                    o_phase    = b_hex ? PH_BODY : PH_IDLE;
                    o_hex_high = 4'd0;
                end
                PH_JOIN: begin
                    if (b_space) begin
                        o_phase = PH_JOIN;
                    end else if (i_byte == CH_QUOTE) begin
                        o_phase = PH_BODY;
                    end else begin
                        o_phase    = PH_IDLE;
                        o_hex_high = 4'd0;
                    end
                end
                default: begin
                    o_phase    = (i_byte == CH_QUOTE) ? PH_BODY : PH_IDLE;
                    o_hex_high = 4'd0;
                end
            endcase
        end
    end

    // result
    always_comb begin
        o_res            = '0;
        o_res.byte_taken = 1'b1;
        if (body_go) begin
            if (i_byte == CH_QUOTE) begin
                o_res.vld      = i_preproc;
                o_res.finished = i_preproc;
            end else if (i_byte == CH_BSLASH) begin
                o_res.vld = 1'b0;
            end else if ((i_byte == CH_LF) || (i_byte == CH_NUL)) begin
                o_res.vld      = i_preproc || (i_byte == CH_NUL);
                o_res.finished = 1'b1;
                o_res.fault    = FLT_BAD_STR;
            end else begin
                o_res.vld        = 1'b1;
                o_res.char_out   = i_byte;
                o_res.char_valid = 1'b1;
            end
        end else begin
            case (i_phase)
                PH_LNSKP: begin
                    o_res.vld = 1'b0;
                end
                PH_ESC: begin
                    if (b_hex) begin
                        o_res.vld = 1'b0;
                    end else if (b_simple_esc) begin
                        o_res.vld        = 1'b1;
                        o_res.char_valid = 1'b1;
                        if (i_byte == CH_LO_N) begin
                            o_res.char_out = CH_LF;
                        end else if (i_byte == CH_LO_T) begin
                            o_res.char_out = CH_TAB;
                        end else begin
                            o_res.char_out = i_byte;
                        end
                    end else begin
                        o_res.vld      = 1'b1;
                        o_res.finished = 1'b1;
                        o_res.fault    = FLT_BAD_ESC;
                    end
                end
                PH_HEX2: begin
                    o_res.vld = 1'b1;
                    if (b_hex) begin
                        o_res.char_out   = {i_hex_high, hex_val(i_byte)};
                        o_res.char_valid = 1'b1;
                    end else begin
                        o_res.finished = 1'b1;
                        o_res.fault    = FLT_BAD_ESC;
                    end
                end
                PH_JOIN: begin
                    if (!b_space && (i_byte != CH_QUOTE)) begin
                        o_res.vld        = 1'b1;
                        o_res.finished   = 1'b1;
                        o_res.byte_taken = 1'b0;
                    end
                end
                default: begin
                    if (i_byte != CH_QUOTE) begin
                        o_res.vld        = 1'b1;
                        o_res.finished   = 1'b1;
                        o_res.byte_taken = 1'b0;
                        o_res.fault      = FLT_NO_QUOTE;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sled_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sled_checker: port-level checks for the string literal decoder
// Watches the top-level ports and flags result records that cannot occur.
// ----------------------------------------------------------------------------
module sled_checker
    import sled_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_char_out,
    input wire logic       o_char_valid,
    input wire logic       o_finished,
    input wire logic       o_byte_taken,
    input wire logic [1:0] o_fault
);

    // a stalled result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_char_out) &&
        $stable(o_char_valid) && $stable(o_finished) && $stable(o_fault))
        else $error("result changed while stalled");

    // input back-pressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output stall");

    a_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_char_valid |-> !o_finished && (o_fault == FLT_NONE) && o_byte_taken)
        else $error("content byte carries end or fault");

    a_fault_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_fault != FLT_NONE) |-> o_finished && !o_char_valid)
        else $error("fault without end of literal");

    a_untaken_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_taken |-> o_finished &&
        ((o_fault == FLT_NONE) || (o_fault == FLT_NO_QUOTE)))
        else $error("untaken byte without end");

endmodule

bind string_literal_escape_decoder_unit sled_checker u_sled_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_char_out   (o_char_out),
    .o_char_valid (o_char_valid),
    .o_finished   (o_finished),
    .o_byte_taken (o_byte_taken),
    .o_fault      (o_fault)
);

`default_nettype wire
